// File: rtl/core/apjb_pkg.sv
package apjb_pkg;

   localparam int DEF_RING_DEPTH = 16384;
   localparam int DEF_CHUNK_LEN  = 48;

   localparam int SAMPLE_W = 24;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int STAT_W   = 32;
   localparam int CSR_W    = 15;
   localparam int TGT_W    = 14;
   localparam int LIM_W    = 8;

   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_CHUNK = 2'd1;
   localparam logic [1:0] KIND_COUNT = 2'd2;

   localparam logic [1:0] CSR_TARGET = 2'd0;
   localparam logic [1:0] CSR_RING   = 2'd1;
   localparam logic [1:0] CSR_STARVE = 2'd2;

   localparam int N_STATS    = 14;
   localparam int C_PACKETS  = 0;
   localparam int C_B0       = 1;
   localparam int C_B1       = 2;
   localparam int C_B2       = 3;
   localparam int C_B3       = 4;
   localparam int C_B4       = 5;
   localparam int C_LATE     = 6;
   localparam int C_TIGHT    = 7;
   localparam int C_DROPPED  = 8;
   localparam int C_SILENCE  = 9;
   localparam int C_UNDERRUN = 10;
   localparam int C_TRIM     = 11;
   localparam int C_PAD      = 12;
   localparam int C_PLAYED   = 13;

   localparam logic [3:0] SEL_WORST = 4'd14;
   localparam logic [3:0] SEL_FILL  = 4'd15;

   localparam int RST_TARGET = 4800;
   localparam int RST_RING   = 9600;
   localparam int RST_LIMIT  = 40;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

// File: rtl/core/audio_playout_jitter_buffer.sv
// Push: one word per cycle while req_ready is high. Chunk request: CHUNK_LEN result
// words at one per cycle unless the response side stalls, via the pending stage and
// the output register; ring reads use one synchronous memory port. Counter read: one
// word, via the pending stage and the output register. A ring_size write stalls the
// request channel while the new size is applied. Reset is synchronous; afterwards a
// clearing pass zeroes every ring entry, during which no request is taken.
module audio_playout_jitter_buffer #(
   parameter int RING_DEPTH = apjb_pkg::DEF_RING_DEPTH,
   parameter int CHUNK_LEN  = apjb_pkg::DEF_CHUNK_LEN
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_kind,
   input  apjb_pkg::sample_type         req_left_in,
   input  apjb_pkg::sample_type         req_right_in,
   input  logic                         req_packet_start,
   input  logic [3:0]                   req_counter_select,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output apjb_pkg::sample_type         rsp_left_out,
   output apjb_pkg::sample_type         rsp_right_out,
   output logic                         rsp_from_ring,
   output logic                         rsp_last,
   output logic [apjb_pkg::STAT_W-1:0]  rsp_counter_value,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [apjb_pkg::CSR_W-1:0]   csr_wdata
);
   import apjb_pkg::*;

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int FW  = $clog2(RING_DEPTH + 1);
   localparam int WW  = $clog2(RING_DEPTH + 2);
   localparam int CW  = FW + 4;
   localparam int KW  = $clog2(CHUNK_LEN);
   localparam int PW  = $clog2(CHUNK_LEN + 1);
   localparam int VW  = (FW > CSR_W) ? FW : CSR_W;
   localparam int REC_SH = 24;
   localparam int REC_M  = (1 << REC_SH) / CHUNK_LEN + 1;
   localparam int MW  = $clog2(REC_M + 1);
   localparam int RST_V0 = (RST_RING > RING_DEPTH) ? RING_DEPTH : RST_RING;
   localparam int RST_V1 = RST_V0 - RST_V0 % CHUNK_LEN;
   localparam int RST_R  = (RST_V1 < 2 * CHUNK_LEN) ? 2 * CHUNK_LEN : RST_V1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PLAY  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [FRAME_W-1:0] ring_mem [RING_DEPTH];
   logic [FRAME_W-1:0] mem_q_ff;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [TGT_W-1:0]  target_ff, target_in;
   logic [FW-1:0]     ring_ff, ring_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [VW-1:0]     quot_ff, quot_in;
   logic              quot_vld_ff, quot_vld_in;
   logic [AW-1:0]     rp_ff, rp_in, wp_ff, wp_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              primed_ff, primed_in;
   logic [LIM_W-1:0]  starve_ff, starve_in;
   logic [1:0]        phase_ff, phase_in;
   logic [PW-1:0]     pfc_ff, pfc_in;
   logic [WW-1:0]     worst_ff, worst_in;
   logic [STAT_W-1:0] stat_ff [N_STATS];
   logic [STAT_W-1:0] stat_in [N_STATS];
   logic [PW-1:0]     stat_add [N_STATS];
   logic [KW-1:0]     k_ff, k_in;
   logic [PW-1:0]     copied_ff, copied_in;

   logic              pend_ff, pend_in;
   logic              pend_ring_ff, pend_ring_in;
   logic              pend_last_ff, pend_last_in;
   logic [STAT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic              out_vld_ff, out_vld_in;
   sample_type        out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic              out_ring_ff, out_ring_in;
   logic              out_last_ff, out_last_in;
   logic [STAT_W-1:0] out_cnt_ff, out_cnt_in;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_wa, mem_ra;
   logic [FRAME_W-1:0] mem_wd;

   logic              move, slot_ok, acc;
   logic [CW-1:0]     fe, te, re, tc, ceil3, f2;
   logic [VW-1:0]     csr_v;
   logic [VW+MW-1:0]  prod;
   logic [FW+PW:0]    rnew;
   logic [FW-1:0]     rclamp;
   logic [FW-1:0]     rp_inc, wp_inc;
   logic [AW-1:0]     rp_next, rp_prev, wp_next;
   logic [FW-1:0]     fcur;
   logic [AW-1:0]     rcur;
   logic              play;
   logic [LIM_W-1:0]  sc_inc;
   logic [STAT_W-1:0] cnt_val;

   assign move    = pend_ff && (!out_vld_ff || rsp_ready);
   assign slot_ok = !pend_ff || move;
   assign req_ready = (state_ff == ST_IDLE) && !quot_vld_ff &&
                      ((req_kind != KIND_COUNT) || slot_ok);
   assign acc = req_valid && req_ready;

   assign fe = CW'(fill_ff);
   assign re = CW'(ring_ff);
   assign ceil3 = (re >> 2) + ((re >> 2) << 1);
   assign te = CW'(target_ff);
   assign tc = (te < ceil3) ? te : ceil3;
   assign f2 = fe << 1;

   assign csr_v = (VW'(csr_wdata) > VW'(RING_DEPTH)) ? VW'(RING_DEPTH) : VW'(csr_wdata);
   assign prod  = (VW+MW)'(csr_v) * (VW+MW)'(REC_M);
   assign rnew  = (FW+PW+1)'(quot_ff) * (FW+PW+1)'(CHUNK_LEN);
   assign rclamp = (rnew < (FW+PW+1)'(2 * CHUNK_LEN)) ? FW'(2 * CHUNK_LEN) : FW'(rnew);

   assign rp_inc  = FW'(rp_ff) + FW'(1);
   assign rp_next = (rp_inc == ring_ff) ? '0 : AW'(rp_inc);
   assign rp_prev = (rp_ff == '0) ? AW'(ring_ff - FW'(1)) : rp_ff - AW'(1);
   assign wp_inc  = FW'(wp_ff) + FW'(1);
   assign wp_next = (wp_inc == ring_ff) ? '0 : AW'(wp_inc);
   assign sc_inc  = starve_ff + LIM_W'(1);

   always_comb begin
      unique case (req_counter_select)
         SEL_WORST: cnt_val = (worst_ff <= WW'(ring_ff)) ? STAT_W'(worst_ff) : '0;
         SEL_FILL:  cnt_val = STAT_W'(fill_ff);
         default:   cnt_val = stat_ff[req_counter_select];
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      target_in   = target_ff;
      ring_in     = ring_ff;
      limit_in    = limit_ff;
      quot_in     = quot_ff;
      quot_vld_in = 1'b0;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      primed_in   = primed_ff;
      starve_in   = starve_ff;
      phase_in    = phase_ff;
      pfc_in      = pfc_ff;
      worst_in    = worst_ff;
      k_in        = k_ff;
      copied_in   = copied_ff;
      for (int i = 0; i < N_STATS; i++) stat_add[i] = '0;
      mem_we = 1'b0;
      mem_wa = wp_ff;
      mem_wd = {req_left_in, req_right_in};
      mem_re = 1'b0;
      mem_ra = rp_ff;
      pend_in      = move ? 1'b0 : pend_ff;
      pend_ring_in = pend_ring_ff;
      pend_last_in = pend_last_ff;
      pend_cnt_in  = pend_cnt_ff;
      fcur = fill_ff;
      rcur = rp_ff;
      play = 1'b1;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET: target_in = csr_wdata[TGT_W-1:0];
            CSR_RING: begin
               quot_in     = prod[REC_SH +: VW];
               quot_vld_in = 1'b1;
            end
            CSR_STARVE: limit_in = csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(RING_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_PLAY: begin
            if (slot_ok) begin
               pend_in      = 1'b1;
               pend_ring_in = PW'(k_ff) < copied_ff;
               pend_last_in = k_ff == KW'(CHUNK_LEN - 1);
               pend_cnt_in  = '0;
               if (PW'(k_ff) < copied_ff) begin
                  mem_re = 1'b1;
                  rp_in  = rp_next;
               end
               k_in = k_ff + KW'(1);
               if (k_ff == KW'(CHUNK_LEN - 1)) state_in = ST_IDLE;
            end
         end
         default: begin
            if (acc) begin
               unique case (req_kind)
                  KIND_PUSH: begin
                     play = 1'b1;
                     if (req_packet_start) begin
                        pfc_in = PW'(1);
                        stat_add[C_PACKETS] = PW'(1);
                        if (primed_ff) begin
                           if (WW'(fill_ff) < worst_ff) worst_in = WW'(fill_ff);
                           if (tc == '0) stat_add[C_B4] = PW'(1);
                           else if ((fe << 3) + (fe << 1) < tc) stat_add[C_B0] = PW'(1);
                           else if ((fe << 2) < tc) stat_add[C_B1] = PW'(1);
                           else if (f2 < tc) stat_add[C_B2] = PW'(1);
                           else if ((fe << 2) < (tc << 1) + tc) stat_add[C_B3] = PW'(1);
                           else stat_add[C_B4] = PW'(1);
                           if (fill_ff == '0) stat_add[C_LATE] = PW'(1);
                           else if (f2 < (tc >> 1)) stat_add[C_TIGHT] = PW'(1);
                        end
                     end else if (pfc_ff >= PW'(CHUNK_LEN)) begin
                        play = 1'b0;
                     end else begin
                        pfc_in = pfc_ff + PW'(1);
                     end
                     if (play) begin
                        if (fill_ff == ring_ff) begin
                           rp_in = rp_next;
                           fcur  = fill_ff - FW'(1);
                           stat_add[C_DROPPED] = PW'(1);
                        end
                        mem_we  = 1'b1;
                        wp_in   = wp_next;
                        fill_in = fcur + FW'(1);
                     end
                  end
                  KIND_CHUNK: begin
                     if (!primed_ff) begin
                        if (fe >= tc) begin
                           primed_in = 1'b1;
                           starve_in = '0;
                        end else begin
                           play = 1'b0;
                        end
                     end
                     if (play && fill_ff == '0) begin
                        stat_add[C_SILENCE] = PW'(CHUNK_LEN);
                        if (starve_ff == '0) stat_add[C_UNDERRUN] = PW'(1);
                        starve_in = sc_inc;
                        if (sc_inc >= limit_ff) begin
                           primed_in = 1'b0;
                           starve_in = '0;
                        end
                        play = 1'b0;
                     end
                     copied_in = '0;
                     if (play) begin
                        starve_in = '0;
                        if (f2 > (tc << 1) + ((((re << 1) - (tc << 1))) >> 2)) begin
                           rcur = rp_next;
                           fcur = fill_ff - FW'(1);
                           stat_add[C_TRIM] = PW'(1);
                        end else if (f2 < (((tc << 2) + (tc << 1)) >> 2)) begin
                           if (f2 < tc || phase_ff == 2'd0) begin
                              rcur = rp_prev;
                              fcur = fill_ff + FW'(1);
                              stat_add[C_PAD] = PW'(1);
                           end
                           if (!(f2 < tc)) phase_in = phase_ff + 2'd1;
                        end
                        copied_in = (fcur < FW'(CHUNK_LEN)) ? PW'(fcur) : PW'(CHUNK_LEN);
                        rp_in   = rcur;
                        fill_in = fcur - FW'(copied_in);
                        stat_add[C_PLAYED]  = copied_in;
                        stat_add[C_SILENCE] = PW'(CHUNK_LEN) - copied_in;
                     end
                     k_in     = '0;
                     state_in = ST_PLAY;
                  end
                  KIND_COUNT: begin
                     pend_in      = 1'b1;
                     pend_ring_in = 1'b0;
                     pend_last_in = 1'b1;
                     pend_cnt_in  = cnt_val;
                  end
                  default: ;
               endcase
            end
         end
      endcase

      if (quot_vld_ff) begin
         ring_in   = rclamp;
         rp_in     = '0;
         wp_in     = '0;
         fill_in   = '0;
         primed_in = 1'b0;
         starve_in = '0;
         pfc_in    = '0;
         worst_in  = WW'(rclamp) + WW'(1);
      end

      for (int i = 0; i < N_STATS; i++) stat_in[i] = stat_ff[i] + STAT_W'(stat_add[i]);

      out_vld_in  = move ? 1'b1 : (out_vld_ff && !rsp_ready);
      out_l_in    = out_l_ff;
      out_r_in    = out_r_ff;
      out_ring_in = out_ring_ff;
      out_last_in = out_last_ff;
      out_cnt_in  = out_cnt_ff;
      if (move) begin
         out_l_in    = pend_ring_ff ? sample_type'(mem_q_ff[FRAME_W-1:SAMPLE_W]) : '0;
         out_r_in    = pend_ring_ff ? sample_type'(mem_q_ff[SAMPLE_W-1:0]) : '0;
         out_ring_in = pend_ring_ff;
         out_last_in = pend_last_ff;
         out_cnt_in  = pend_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[mem_wa] <= mem_wd;
      if (mem_re) mem_q_ff <= ring_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         target_ff   <= TGT_W'(RST_TARGET);
         ring_ff     <= FW'(RST_R);
         limit_ff    <= LIM_W'(RST_LIMIT);
         quot_vld_ff <= 1'b0;
         rp_ff       <= '0;
         wp_ff       <= '0;
         fill_ff     <= '0;
         primed_ff   <= 1'b0;
         starve_ff   <= '0;
         phase_ff    <= '0;
         pfc_ff      <= '0;
         worst_ff    <= WW'(RST_R + 1);
         k_ff        <= '0;
         copied_ff   <= '0;
         pend_ff     <= 1'b0;
         out_vld_ff  <= 1'b0;
         for (int i = 0; i < N_STATS; i++) stat_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         target_ff   <= target_in;
         ring_ff     <= ring_in;
         limit_ff    <= limit_in;
         quot_vld_ff <= quot_vld_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         primed_ff   <= primed_in;
         starve_ff   <= starve_in;
         phase_ff    <= phase_in;
         pfc_ff      <= pfc_in;
         worst_ff    <= worst_in;
         k_ff        <= k_in;
         copied_ff   <= copied_in;
         pend_ff     <= pend_in;
         out_vld_ff  <= out_vld_in;
         for (int i = 0; i < N_STATS; i++) stat_ff[i] <= stat_in[i];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff      <= quot_in;
      pend_ring_ff <= pend_ring_in;
      pend_last_ff <= pend_last_in;
      pend_cnt_ff  <= pend_cnt_in;
      out_l_ff     <= out_l_in;
      out_r_ff     <= out_r_in;
      out_ring_ff  <= out_ring_in;
      out_last_ff  <= out_last_in;
      out_cnt_ff   <= out_cnt_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_left_out      = out_l_ff;
   assign rsp_right_out     = out_r_ff;
   assign rsp_from_ring     = out_ring_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_counter_value = out_cnt_ff;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import apjb_pkg::*;

   localparam int RDEPTH = DEF_RING_DEPTH;
   localparam int CHUNK = DEF_CHUNK_LEN;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [1:0] CSR_NONE = 2'd3;
   localparam int WATCH_LIMIT = 100000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_kind;
   sample_type req_left_in;
   sample_type req_right_in;
   logic req_packet_start;
   logic [3:0] req_counter_select;
   logic rsp_valid;
   logic rsp_ready;
   sample_type rsp_left_out;
   sample_type rsp_right_out;
   logic rsp_from_ring;
   logic rsp_last;
   logic [STAT_W-1:0] rsp_counter_value;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   audio_playout_jitter_buffer i_dut (.*);

   typedef struct {
      sample_type l;
      sample_type r;
      logic fr;
      logic lst;
      logic [STAT_W-1:0] val;
   } play_word_type;

   typedef struct {
      bit is_cfg;
      logic [1:0] idx;
      int unsigned cval;
      logic [1:0] kind;
      sample_type l;
      sample_type r;
      logic ps;
      logic [3:0] sel;
      bit has_exp;
      logic [STAT_W-1:0] exp_val;
   } stim_row_type;

   play_word_type play_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit calm = 0;
   int rsp_hold = 0;

   // predictor state
   logic [SAMPLE_W-1:0] ring_l[RDEPTH];
   logic [SAMPLE_W-1:0] ring_r[RDEPTH];
   int unsigned rd_ptr, wr_ptr, fill, starved, pad_ph, pkt_frames, worst;
   bit primed;
   int unsigned stats[N_STATS];
   int unsigned tgt, rsize, slimit;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0h want %0h (pending %0d)", what, got, want, play_q.size());
   endtask

   function automatic int unsigned clamp_ring(int unsigned v);
      if (v > RDEPTH) v = RDEPTH;
      v = v - v % CHUNK;
      if (v < 2 * CHUNK) v = 2 * CHUNK;
      return v;
   endfunction

   function automatic int unsigned target2();
      int unsigned ceil3;
      ceil3 = rsize / 4 * 3;
      return 2 * (tgt < ceil3 ? tgt : ceil3);
   endfunction

   task automatic empty_ring();
      rd_ptr = 0; wr_ptr = 0; fill = 0; primed = 0;
      starved = 0; pkt_frames = 0; worst = rsize + 1;
   endtask

   task automatic model_reset();
      for (int i = 0; i < RDEPTH; i++) begin
         ring_l[i] = '0;
         ring_r[i] = '0;
      end
      for (int i = 0; i < N_STATS; i++) stats[i] = 0;
      tgt = RST_TARGET; rsize = clamp_ring(RST_RING); slimit = RST_LIMIT;
      pad_ph = 0;
      empty_ring();
   endtask

   task automatic model_config(logic [1:0] idx, int unsigned v);
      case (idx)
         CSR_TARGET: tgt = v & 16'h3FFF;
         CSR_RING: begin
            rsize = clamp_ring(v & 16'h7FFF);
            empty_ring();
         end
         CSR_STARVE: slimit = v & 8'hFF;
         default: ;
      endcase
   endtask

   task automatic push_frame(sample_type l, sample_type r, logic ps);
      int unsigned t2, m2, b;
      if (ps) begin
         t2 = target2();
         m2 = 2 * fill;
         pkt_frames = 1;
         stats[C_PACKETS]++;
         if (primed) begin
            if (fill < worst) worst = fill;
            if (t2 == 0) b = 4;
            else if (100 * m2 < 10 * t2) b = 0;
            else if (100 * m2 < 25 * t2) b = 1;
            else if (100 * m2 < 50 * t2) b = 2;
            else if (100 * m2 < 75 * t2) b = 3;
            else b = 4;
            stats[C_B0 + b]++;
            if (fill == 0) stats[C_LATE]++;
            else if (m2 < t2 / 4) stats[C_TIGHT]++;
         end
      end else begin
         if (pkt_frames >= CHUNK) return;
         pkt_frames++;
      end
      if (fill + 1 > rsize) begin
         rd_ptr = (rd_ptr + 1) % rsize;
         fill--;
         stats[C_DROPPED]++;
      end
      ring_l[wr_ptr] = l;
      ring_r[wr_ptr] = r;
      wr_ptr = (wr_ptr + 1) % rsize;
      fill++;
   endtask

   task automatic play_chunk();
      int unsigned t2, c2, f2, copied;
      bit play, urgent, go;
      play_word_type w;
      t2 = target2();
      c2 = 2 * rsize;
      copied = 0;
      play = 1;
      if (!primed) begin
         if (2 * fill >= t2) begin
            primed = 1;
            starved = 0;
         end else play = 0;
      end
      if (play && fill == 0) begin
         stats[C_SILENCE] += CHUNK;
         if (starved == 0) stats[C_UNDERRUN]++;
         starved = (starved + 1) & 8'hFF;
         if (starved >= slimit) begin
            primed = 0;
            starved = 0;
         end
         play = 0;
      end
      if (play) begin
         starved = 0;
         f2 = 2 * fill;
         if (f2 > t2 + (c2 - t2) / 4) begin
            rd_ptr = (rd_ptr + 1) % rsize;
            fill--;
            stats[C_TRIM]++;
         end else if (f2 < t2 * 3 / 4) begin
            urgent = f2 < t2 / 2;
            go = urgent;
            if (!urgent) begin
               go = (pad_ph & 3) == 0;
               pad_ph = (pad_ph + 1) & 3;
            end
            if (go) begin
               rd_ptr = (rd_ptr + rsize - 1) % rsize;
               fill++;
               stats[C_PAD]++;
            end
         end
         copied = fill < CHUNK ? fill : CHUNK;
      end
      for (int k = 0; k < CHUNK; k++) begin
         w.val = '0;
         w.lst = (k == CHUNK - 1);
         if (k < copied) begin
            w.l = ring_l[rd_ptr];
            w.r = ring_r[rd_ptr];
            w.fr = 1;
            rd_ptr = (rd_ptr + 1) % rsize;
         end else begin
            w.l = '0; w.r = '0; w.fr = 0;
         end
         play_q.push_back(w);
      end
      if (play) begin
         fill -= copied;
         stats[C_PLAYED] += copied;
         stats[C_SILENCE] += CHUNK - copied;
      end
   endtask

   function automatic int unsigned read_stat(logic [3:0] sel);
      if (sel < N_STATS) return stats[sel];
      if (sel == SEL_WORST) return worst <= rsize ? worst : 0;
      return fill;
   endfunction

   function automatic int pick_gap();
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic put_word(logic [1:0] k, sample_type l, sample_type r, logic ps,
                           logic [3:0] sel, bit he, logic [STAT_W-1:0] ev);
      play_word_type w;
      int g;
      req_valid <= 1;
      req_kind <= k;
      req_left_in <= l;
      req_right_in <= r;
      req_packet_start <= ps;
      req_counter_select <= sel;
      do @(posedge clock); while (!req_ready);
      case (k)
         KIND_PUSH: push_frame(l, r, ps);
         KIND_CHUNK: play_chunk();
         KIND_COUNT: begin
            w.l = '0; w.r = '0; w.fr = 0; w.lst = 1;
            w.val = he ? ev : read_stat(sel);
            play_q.push_back(w);
         end
         default: ;
      endcase
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (play_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int unsigned v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v[CSR_W-1:0];
      @(posedge clock);
      model_config(idx, v);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic sample_type rnd_sample();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 24'h7FFFFF;
      if (p == 1) return 24'h800000;
      return sample_type'($urandom);
   endfunction

   // response side, checker and watchdog
   always @(posedge clock) begin
      play_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (play_q.size() == 0) report("unexpected word", rsp_counter_value, 0);
         else begin
            w = play_q.pop_front();
            if (rsp_left_out !== w.l) report("left_out", rsp_left_out, w.l);
            if (rsp_right_out !== w.r) report("right_out", rsp_right_out, w.r);
            if (rsp_from_ring !== w.fr) report("from_ring", rsp_from_ring, w.fr);
            if (rsp_last !== w.lst) report("last", rsp_last, w.lst);
            if (rsp_counter_value !== w.val) report("counter_value", rsp_counter_value, w.val);
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if (!calm && $urandom_range(0, 99) < 30)
            rsp_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 3);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("audio_playout_jitter_buffer verification failed");
         $finish;
      end
   end

   stim_row_type dir_rows[$];
   int unsigned ph_tgt[6] = '{40, 72, 0, 12288, 16383, 60};
   int unsigned ph_ring[6] = '{96, 96, 144, 32767, 200, 0};
   int unsigned ph_lim[6] = '{255, 3, 1, 40, 0, 2};

   function automatic stim_row_type mk(logic [1:0] k, sample_type l, sample_type r, logic ps,
                                       logic [3:0] sel, bit he, logic [STAT_W-1:0] ev);
      stim_row_type s;
      s.is_cfg = 0; s.idx = '0; s.cval = 0;
      s.kind = k; s.l = l; s.r = r; s.ps = ps; s.sel = sel; s.has_exp = he; s.exp_val = ev;
      return s;
   endfunction

   function automatic stim_row_type mkc(logic [1:0] idx, int unsigned v);
      stim_row_type s;
      s = mk(KIND_PUSH, '0, '0, 0, '0, 0, '0);
      s.is_cfg = 1; s.idx = idx; s.cval = v;
      return s;
   endfunction

   initial begin
      int items, len;
      stim_row_type s;
      reset <= 1;
      req_valid <= 0;
      req_kind <= KIND_PUSH;
      req_left_in <= '0;
      req_right_in <= '0;
      req_packet_start <= 0;
      req_counter_select <= '0;
      rsp_ready <= 0;
      csr_we <= 0;
      csr_index <= CSR_TARGET;
      csr_wdata <= '0;
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 0;

      dir_rows = '{
         mk(KIND_COUNT, '0, '0, 0, SEL_FILL, 1, 0),
         mk(KIND_COUNT, '0, '0, 0, SEL_WORST, 1, 0),
         mk(KIND_COUNT, '0, '0, 0, 4'(C_PACKETS), 1, 0),
         mk(KIND_CHUNK, '0, '0, 0, '0, 0, 0),
         mkc(CSR_RING, 96),
         mkc(CSR_TARGET, 0),
         mkc(CSR_STARVE, 1),
         mk(KIND_CHUNK, '0, '0, 0, '0, 0, 0),
         mk(KIND_COUNT, '0, '0, 0, 4'(C_UNDERRUN), 0, 0),
         mk(KIND_PUSH, 24'h7FFFFF, 24'h800000, 1, '0, 0, 0),
         mk(KIND_PUSH, 24'h800000, 24'h7FFFFF, 0, '0, 0, 0),
         mk(KIND_NONE, 24'h123456, 24'hFEDCBA, 1, 4'hF, 0, 0),
         mk(KIND_CHUNK, '0, '0, 0, '0, 0, 0),
         mk(KIND_CHUNK, '0, '0, 0, '0, 0, 0),
         mkc(CSR_NONE, 15'h7FFF),
         mkc(CSR_TARGET, 40),
         mk(KIND_PUSH, 24'h000001, 24'hFFFFFF, 1, '0, 0, 0),
         mk(KIND_CHUNK, '0, '0, 0, '0, 0, 0),
         mk(KIND_COUNT, '0, '0, 0, 4'(C_SILENCE), 0, 0),
         mk(KIND_COUNT, '0, '0, 0, 4'(C_PLAYED), 0, 0),
         mk(KIND_COUNT, '0, '0, 0, SEL_WORST, 0, 0),
         mk(KIND_COUNT, '0, '0, 0, SEL_FILL, 0, 0)
      };
      foreach (dir_rows[i]) begin
         s = dir_rows[i];
         if (s.is_cfg) begin
            settle();
            csr_write(s.idx, s.cval);
         end else put_word(s.kind, s.l, s.r, s.ps, s.sel, s.has_exp, s.exp_val);
      end

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         calm = (ph == 2);
         csr_write(CSR_RING, ph_ring[ph]);
         csr_write(CSR_TARGET, ph_tgt[ph]);
         csr_write(CSR_STARVE, ph_lim[ph]);
         items = 0;
         while (items < 20) begin
            case ($urandom_range(0, 19))
               0,1,2,3,4,5,6,7,8,9,10: begin
                  len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 60)
                                                    : $urandom_range(1, 24);
                  for (int f = 0; f < len; f++)
                     put_word(KIND_PUSH, rnd_sample(), rnd_sample(),
                              (f == 0) && ($urandom_range(0, 9) != 0), '0, 0, 0);
                  items += len;
               end
               11,12,13,14,15: begin
                  put_word(KIND_CHUNK, rnd_sample(), rnd_sample(), 1'($urandom), 4'($urandom),
                           0, 0);
                  items++;
               end
               16,17,18: begin
                  put_word(KIND_COUNT, rnd_sample(), rnd_sample(), 1'($urandom), 4'($urandom),
                           0, 0);
                  items++;
               end
               default: begin
                  put_word(KIND_NONE, rnd_sample(), rnd_sample(), 1'($urandom),
                           4'($urandom), 0, 0);
                  items++;
               end
            endcase
         end
      end
      calm = 0;
      for (int sel = 0; sel < 16; sel++) put_word(KIND_COUNT, '0, '0, 0, 4'(sel), 0, 0);
      settle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("audio_playout_jitter_buffer verification clean");
      else $display("audio_playout_jitter_buffer verification failed");
      $finish;
   end

endmodule

// File: audio_playout_jitter_buffer.f
rtl/core/apjb_pkg.sv
rtl/core/audio_playout_jitter_buffer.sv
verif/tb_top.sv
